/* design/v3a_pkg.sv */
// ----------------------------------------------------------------------------
// v3a_pkg : shared types and constants for the fixed-point vector unit
// payload beats, per-stage carry data and the square root / divide cell state
// ----------------------------------------------------------------------------
package v3a_pkg;

   localparam int SQRT_STEPS = 32;   // one root bit per cell
   localparam int DIV_STEPS  = 18;   // quotient bits of a normalized component
   localparam int NUM_W      = 50;   // (|a| << 17) + magnitude
   localparam int REM_W      = 34;
   localparam int DEN_W      = 33;   // 2 * magnitude

   localparam logic [2:0] OP_SCALE  = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_CROSS  = 3'd3;
   localparam logic [2:0] OP_LENGTH = 3'd4;
   localparam logic [2:0] OP_NORM   = 3'd5;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scale_factor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_x;
      logic signed [31:0] res_y;
      logic signed [31:0] res_z;
      logic [31:0]        magnitude;
      logic               overflow;
      logic               zero_length;
   } rsp_type;

   // data that rides along the cell chains
   typedef struct packed {
      logic [2:0]        op;
      logic [2:0][31:0]  res;
      logic [31:0]       mag;
      logic              ov;
      logic              zl;
      logic [2:0]        neg;
      logic [2:0][31:0]  absa;
   } side_type;

   typedef struct packed {
      logic [31:0]      root;
      logic [REM_W-1:0] rem;
      logic [63:0]      srest;
   } sqrt_type;

   typedef struct packed {
      logic [DEN_W-1:0]                den;
      logic [2:0][REM_W-1:0]           rem;
      logic [2:0][NUM_W-1:0]           num;
      logic [2:0][DIV_STEPS-1:0]       quo;
   } div_type;

endpackage

/* design/v3a_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// v3a_sqrt_cell : one restoring square root step
// brings down two radicand bits and decides one root bit
// ----------------------------------------------------------------------------
module v3a_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  v3a_pkg::sqrt_type up_sq,
   input  v3a_pkg::side_type up_side,
   output logic              dn_valid,
   output v3a_pkg::sqrt_type dn_sq,
   output v3a_pkg::side_type dn_side
);
   import v3a_pkg::*;

   logic       valid_ff;
   sqrt_type   sq_ff, sq_in;
   side_type   side_ff;
   logic [REM_W+1:0] shifted, trial, diff;

   always_comb begin
      shifted = {up_sq.rem, up_sq.srest[63:62]};
      trial   = {2'b00, up_sq.root, 2'b01};
      diff    = shifted - trial;
      sq_in.srest = {up_sq.srest[61:0], 2'b00};
      if (shifted >= trial) begin
         sq_in.rem  = diff[REM_W-1:0];
         sq_in.root = {up_sq.root[30:0], 1'b1};
      end else begin
         sq_in.rem  = shifted[REM_W-1:0];
         sq_in.root = {up_sq.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
      if (en) begin
         sq_ff   <= sq_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_sq    = sq_ff;
   assign dn_side  = side_ff;

endmodule

/* design/v3a_div_cell.sv */
// ----------------------------------------------------------------------------
// v3a_div_cell : one restoring divide step on three lanes
// shifts in one dividend bit per lane and decides one quotient bit
// ----------------------------------------------------------------------------
module v3a_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  v3a_pkg::div_type  up_dv,
   input  v3a_pkg::side_type up_side,
   output logic              dn_valid,
   output v3a_pkg::div_type  dn_dv,
   output v3a_pkg::side_type dn_side
);
   import v3a_pkg::*;

   logic       valid_ff;
   div_type    dv_ff, dv_in;
   side_type   side_ff;
   logic [REM_W-1:0] part [3];

   always_comb begin
      dv_in.den = up_dv.den;
      for (int i = 0; i < 3; i++) begin
         part[i] = {up_dv.rem[i][REM_W-2:0], up_dv.num[i][NUM_W-1]};
         dv_in.num[i] = {up_dv.num[i][NUM_W-2:0], 1'b0};
         if (part[i] >= {1'b0, up_dv.den}) begin
            dv_in.rem[i] = part[i] - {1'b0, up_dv.den};
            dv_in.quo[i] = {up_dv.quo[i][DIV_STEPS-2:0], 1'b1};
         end else begin
            dv_in.rem[i] = part[i];
            dv_in.quo[i] = {up_dv.quo[i][DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
      if (en) begin
         dv_ff   <= dv_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_dv    = dv_ff;
   assign dn_side  = side_ff;

endmodule

/* design/vec3_fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu : pipelined Q16.16 3d vector unit
// scale, add, subtract, cross product, length and normalize on one stream
// ----------------------------------------------------------------------------
// The unit takes one request beat per cycle while req_ready is high and
// returns one response beat per request, in order. The chain is one multiply
// stage, one round/sum stage, 32 square root cells (one root bit each), one
// rounding stage, 18 divide cells (one quotient bit of each normalized
// component each) and the output register. Every operation travels the full
// chain so results never reorder. When a response beat waits, the whole chain
// holds and req_ready drops in the same cycle; it is high whenever the output
// register is empty or being taken.
module vec3_fixed_point_alu (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  v3a_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output v3a_pkg::rsp_type rsp_data
);
   import v3a_pkg::*;

   // round Q32.32 to Q16.16 half up, saturate; returns {overflow, value}
   function automatic logic [32:0] q_round(input logic signed [64:0] v);
      logic signed [64:0] t;
      logic signed [48:0] f;
      t = v + 65'sd32768;
      f = t[64:16];
      if ((&f[48:31]) || !(|f[48:31])) begin
         q_round = {1'b0, f[31:0]};
      end else begin
         q_round = {1'b1, f[48] ? 32'h8000_0000 : 32'h7fff_ffff};
      end
   endfunction

   logic adv;                      // whole chain moves
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: operand select, products and saturated add/sub
   logic signed [31:0] av [3], bv [3];
   logic signed [31:0] ma [6], mb [6];
   logic signed [63:0] prod_in [6];
   logic signed [32:0] as_sum [3];
   logic [2:0][31:0]   as_res;
   logic               as_ov;

   logic               s1_valid_ff;
   logic [2:0]         s1_op_ff;
   logic signed [63:0] s1_prod_ff [6];
   logic [2:0][31:0]   s1_res_ff;
   logic               s1_ov_ff;
   logic [2:0]         s1_neg_ff;
   logic [2:0][31:0]   s1_abs_ff;

   always_comb begin
      av[0] = req_data.a_x; av[1] = req_data.a_y; av[2] = req_data.a_z;
      bv[0] = req_data.b_x; bv[1] = req_data.b_y; bv[2] = req_data.b_z;
      for (int i = 0; i < 6; i++) begin
         ma[i] = '0;
         mb[i] = '0;
      end
      case (req_data.op)
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = av[i];
               mb[i] = req_data.scale_factor;
            end
         end
         OP_CROSS: begin
            ma[0] = av[1]; mb[0] = bv[2];
            ma[1] = av[2]; mb[1] = bv[0];
            ma[2] = av[0]; mb[2] = bv[1];
            ma[3] = av[2]; mb[3] = bv[1];
            ma[4] = av[0]; mb[4] = bv[2];
            ma[5] = av[1]; mb[5] = bv[0];
         end
         default: begin
            // squares for length / normalize
            for (int i = 0; i < 3; i++) begin
               ma[i] = av[i];
               mb[i] = av[i];
            end
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         prod_in[i] = ma[i] * mb[i];
      end
      as_ov = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (req_data.op == OP_SUB) begin
            as_sum[i] = 33'(av[i]) - 33'(bv[i]);
         end else begin
            as_sum[i] = 33'(av[i]) + 33'(bv[i]);
         end
         if (as_sum[i][32] != as_sum[i][31]) begin
            as_ov     = 1'b1;
            as_res[i] = as_sum[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            as_res[i] = as_sum[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         s1_op_ff  <= req_data.op;
         s1_prod_ff <= prod_in;
         s1_res_ff <= as_res;
         s1_ov_ff  <= as_ov;
         for (int i = 0; i < 3; i++) begin
            s1_neg_ff[i] <= av[i][31];
            s1_abs_ff[i] <= av[i][31] ? -av[i] : av[i];
         end
      end
   end

   // ---------------- stage 2: rounding, saturation and sum of squares
   logic [SQRT_STEPS:0] sq_valid;
   sqrt_type            sq_d    [SQRT_STEPS+1];
   side_type            sq_side [SQRT_STEPS+1];

   logic [32:0]         qr [3];
   logic [63:0]         sumsq;
   side_type            side2_in;
   sqrt_type            sq2_in;
   logic                s2_valid_ff;
   side_type            s2_side_ff;
   sqrt_type            s2_sq_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s1_op_ff == OP_CROSS) begin
            qr[i] = q_round(65'(s1_prod_ff[i]) - 65'(s1_prod_ff[i+3]));
         end else begin
            qr[i] = q_round(65'(s1_prod_ff[i]));
         end
      end
      sumsq = s1_prod_ff[0] + s1_prod_ff[1] + s1_prod_ff[2];
      side2_in.op   = s1_op_ff;
      side2_in.mag  = '0;
      side2_in.zl   = 1'b0;
      side2_in.neg  = s1_neg_ff;
      side2_in.absa = s1_abs_ff;
      case (s1_op_ff)
         OP_SCALE, OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               side2_in.res[i] = qr[i][31:0];
            end
            side2_in.ov = qr[0][32] | qr[1][32] | qr[2][32];
         end
         OP_ADD, OP_SUB: begin
            side2_in.res = s1_res_ff;
            side2_in.ov  = s1_ov_ff;
         end
         default: begin
            side2_in.res = '0;
            side2_in.ov  = 1'b0;
         end
      endcase
      sq2_in.root  = '0;
      sq2_in.rem   = '0;
      sq2_in.srest = sumsq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_side_ff <= side2_in;
         s2_sq_ff   <= sq2_in;
      end
   end

   // ---------------- square root chain
   assign sq_valid[0] = s2_valid_ff;
   assign sq_d[0]     = s2_sq_ff;
   assign sq_side[0]  = s2_side_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      v3a_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .up_valid (sq_valid[k]),
         .up_sq    (sq_d[k]),
         .up_side  (sq_side[k]),
         .dn_valid (sq_valid[k+1]),
         .dn_sq    (sq_d[k+1]),
         .dn_side  (sq_side[k+1])
      );
   end

   // ---------------- rounding of the root, divider setup
   logic [DIV_STEPS:0] dv_valid;
   div_type            dv_d    [DIV_STEPS+1];
   side_type           dv_side [DIV_STEPS+1];

   sqrt_type            sq_last;
   side_type            side3_in;
   div_type             dv3_in;
   logic [32:0]         mag_wide;
   logic [31:0]         mag_sat;
   logic                mag_ov;
   logic                is_zero;
   logic [NUM_W-1:0]    numer [3];
   logic                s3_valid_ff;
   side_type            s3_side_ff;
   div_type             s3_dv_ff;

   always_comb begin
      sq_last  = sq_d[SQRT_STEPS];
      is_zero  = (sq_last.root == '0) && (sq_last.rem == '0);
      mag_wide = {1'b0, sq_last.root} +
                 33'(sq_last.rem > {{(REM_W-32){1'b0}}, sq_last.root});
      mag_ov   = mag_wide[32];
      mag_sat  = mag_ov ? 32'hffff_ffff : mag_wide[31:0];
      side3_in = sq_side[SQRT_STEPS];
      if (side3_in.op == OP_LENGTH || side3_in.op == OP_NORM) begin
         side3_in.mag = mag_sat;
         side3_in.ov  = mag_ov;
         side3_in.zl  = is_zero;
      end
      dv3_in.den = {mag_sat, 1'b0};
      for (int i = 0; i < 3; i++) begin
         numer[i] = NUM_W'({side3_in.absa[i], 17'b0}) + NUM_W'(mag_sat);
         // upper bits start the partial remainder, the low bits shift in
         dv3_in.rem[i] = REM_W'(numer[i][NUM_W-1:DIV_STEPS]);
         dv3_in.num[i] = {numer[i][DIV_STEPS-1:0], {(NUM_W-DIV_STEPS){1'b0}}};
         dv3_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= sq_valid[SQRT_STEPS];
      end
      if (adv) begin
         s3_side_ff <= side3_in;
         s3_dv_ff   <= dv3_in;
      end
   end

   // ---------------- divide chain for normalize
   assign dv_valid[0] = s3_valid_ff;
   assign dv_d[0]     = s3_dv_ff;
   assign dv_side[0]  = s3_side_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      v3a_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .up_valid (dv_valid[k]),
         .up_dv    (dv_d[k]),
         .up_side  (dv_side[k]),
         .dn_valid (dv_valid[k+1]),
         .dn_dv    (dv_d[k+1]),
         .dn_side  (dv_side[k+1])
      );
   end

   // ---------------- output register
   side_type    side_last;
   div_type     dv_last;
   logic [31:0] unit [3];
   rsp_type     rsp_in;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   always_comb begin
      side_last = dv_side[DIV_STEPS];
      dv_last   = dv_d[DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
         unit[i] = 32'(dv_last.quo[i]);
         if (side_last.neg[i]) begin
            unit[i] = -unit[i];
         end
      end
      if (side_last.op == OP_NORM && !side_last.zl) begin
         rsp_in.res_x = unit[0];
         rsp_in.res_y = unit[1];
         rsp_in.res_z = unit[2];
      end else begin
         rsp_in.res_x = side_last.res[0];
         rsp_in.res_y = side_last.res[1];
         rsp_in.res_z = side_last.res[2];
      end
      rsp_in.magnitude   = side_last.mag;
      rsp_in.overflow    = side_last.ov;
      rsp_in.zero_length = side_last.zl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[DIV_STEPS];
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks
   // zero length beat carries an all-zero vector and magnitude
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.magnitude == '0 && rsp_data.res_x == '0 &&
         rsp_data.res_y == '0 && rsp_data.res_z == '0)
      else $error("zero length beat with nonzero data");

   // saturation and zero length never come together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.overflow && rsp_data.zero_length))
      else $error("overflow and zero length both set");

   // a held response freezes the chain, so nothing new is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // reset empties the output
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
